[hdl/mtel_pkg.sv]
// ---------------------------------------------------------------------------
// mtel_pkg
// Shared types and constants for the move-to-end order list: field widths,
// request codes, job classes and the microcode control word.
// ---------------------------------------------------------------------------
package mtel_pkg;

	localparam int ELEMENTS    = 1024;
	localparam int VAL_W       = 11;
	localparam int ADDR_W      = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [1:0] REQ_LEFT  = 2'd0;
	localparam logic [1:0] REQ_RIGHT = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef enum logic [2:0] {
		J_BAD   = 3'd0,
		J_NOP   = 3'd1,
		J_READ  = 3'd2,
		J_LEFT  = 3'd3,
		J_RIGHT = 3'd4
	} job_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE = 4'd0;
	localparam step_t ST_L1   = 4'd1;
	localparam step_t ST_L2   = 4'd2;
	localparam step_t ST_L3   = 4'd3;
	localparam step_t ST_R1   = 4'd4;
	localparam step_t ST_R2   = 4'd5;
	localparam step_t ST_R3   = 4'd6;
	localparam step_t ST_EMIT = 4'd7;
	localparam step_t ST_CLR  = 4'd8;

	typedef enum logic [1:0] {
		W_NONE   = 2'd0,
		W_ALWAYS = 2'd1,
		W_P_NZ   = 2'd2,
		W_N_NZ   = 2'd3
	} wcond_t;

	typedef enum logic [2:0] {
		A_P    = 3'd0,
		A_N    = 3'd1,
		A_V    = 3'd2,
		A_HEAD = 3'd3,
		A_TAIL = 3'd4,
		A_CLR  = 3'd5
	} asel_t;

	typedef enum logic [2:0] {
		D_P        = 3'd0,
		D_N        = 3'd1,
		D_V        = 3'd2,
		D_HEAD     = 3'd3,
		D_TAIL     = 3'd4,
		D_ZERO     = 3'd5,
		D_CLR_NEXT = 3'd6,
		D_CLR_PREV = 3'd7
	} dsel_t;

	typedef enum logic [1:0] {
		H_KEEP    = 2'd0,
		H_N_IF_P0 = 2'd1,
		H_V       = 2'd2
	} hsel_t;

	typedef enum logic [1:0] {
		T_KEEP    = 2'd0,
		T_P_IF_N0 = 2'd1,
		T_V       = 2'd2
	} tsel_t;

	typedef enum logic [2:0] {
		OP_NEXT     = 3'd0,
		OP_GOTO     = 3'd1,
		OP_DISPATCH = 3'd2,
		OP_WAIT_OUT = 3'd3,
		OP_CLEAR    = 3'd4
	} seqop_t;

	typedef struct packed {
		wcond_t nx_wc;
		asel_t  nx_as;
		dsel_t  nx_ds;
		wcond_t pv_wc;
		asel_t  pv_as;
		dsel_t  pv_ds;
		hsel_t  hsel;
		tsel_t  tsel;
		seqop_t op;
		step_t  target;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		job_t job;
		logic out_free;
		logic clr_last;
	} seq_status_t;

endpackage

[hdl/move_to_end_order_list.sv]
// ---------------------------------------------------------------------------
// move_to_end_order_list
// Ordering of the values 1..ELEMENTS kept as a doubly linked list in two link
// tables, with move-to-leftmost, move-to-rightmost and successor reads.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ELEMENTS (1024) entries
// that writes the identity order into the link tables; s_tready stays low
// until it is done. Each request yields one result word. Reads, flagged
// requests and moves of a value already at that end go straight to the emit
// step; a real move first runs L1-L3 or R1-R3, set by the up to three writes
// it makes to the single write port of the predecessor table (left moves)
// or successor table (right moves), steered by the microcode. A finished
// result waits in the output register; new requests are taken meanwhile, and
// the sequencer only holds at its final step if the previous result is untaken.
module move_to_end_order_list
	import mtel_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // item_value[10:0]
	input  logic [1:0]             s_tuser,   // req_type[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // next_value, head_value, tail_value
	output logic                   m_tuser    // bad_request
);

	ctrl_t       ctrl;
	seq_status_t status;

	val_t  nx_mem [ELEMENTS];
	val_t  pv_mem [ELEMENTS];
	val_t  nx_rd_q, pv_rd_q;
	val_t  v_q, head_q, tail_q;
	job_t  job_q, job_in;
	addr_t clr_q;

	val_t  in_val, nx_wa, pv_wa, nx_wd, pv_wd;
	addr_t nx_idx, pv_idx, rd_idx;
	logic  nx_we, pv_we, accept, out_free, emit, in_range, clr_last;
	logic  p_nz, n_nz;

	val_t  o_next_q, o_head_q, o_tail_q;
	logic  o_bad_q, m_tvalid_q;

	mtel_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_val   = s_tdata[VAL_W-1:0];
	assign s_tready = (ctrl.op == OP_DISPATCH);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = (ctrl.op == OP_WAIT_OUT) && out_free;
	assign in_range = 32'(in_val) <= ELEMENTS;
	assign clr_last = (clr_q == addr_t'(ELEMENTS - 1));
	assign p_nz     = (pv_rd_q != '0);
	assign n_nz     = (nx_rd_q != '0);
	assign rd_idx   = addr_t'(in_val - val_t'(1));

	always_comb begin
		job_in = J_BAD;
		unique case (s_tuser)
			REQ_LEFT: begin
				if (in_val == '0 || !in_range) job_in = J_BAD;
				else if (in_val == head_q)    job_in = J_NOP;
				else                          job_in = J_LEFT;
			end
			REQ_RIGHT: begin
				if (in_val == '0 || !in_range) job_in = J_BAD;
				else if (in_val == tail_q)    job_in = J_NOP;
				else                          job_in = J_RIGHT;
			end
			REQ_READ: job_in = in_range ? J_READ : J_BAD;
			default:  job_in = J_BAD;
		endcase
	end

	assign status = '{accept, job_in, out_free, clr_last};

	function automatic val_t pick_addr(asel_t s, val_t p, val_t n, val_t v, val_t h, val_t t);
		val_t r;
		r = v;
		unique case (s)
			A_P:     r = p;
			A_N:     r = n;
			A_V:     r = v;
			A_HEAD:  r = h;
			A_TAIL:  r = t;
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic val_t pick_data(dsel_t s, val_t p, val_t n, val_t v, val_t h, val_t t,
		addr_t c, logic last);
		val_t r;
		r = '0;
		unique case (s)
			D_P:        r = p;
			D_N:        r = n;
			D_V:        r = v;
			D_HEAD:     r = h;
			D_TAIL:     r = t;
			D_ZERO:     r = '0;
			D_CLR_NEXT: r = last ? val_t'(0) : val_t'(c) + val_t'(2);
			D_CLR_PREV: r = val_t'(c);
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic wcond_ok(wcond_t c, logic pnz, logic nnz);
		logic r;
		r = 1'b0;
		unique case (c)
			W_NONE:   r = 1'b0;
			W_ALWAYS: r = 1'b1;
			W_P_NZ:   r = pnz;
			W_N_NZ:   r = nnz;
			default:  r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		nx_wa  = pick_addr(ctrl.nx_as, pv_rd_q, nx_rd_q, v_q, head_q, tail_q);
		pv_wa  = pick_addr(ctrl.pv_as, pv_rd_q, nx_rd_q, v_q, head_q, tail_q);
		nx_wd  = pick_data(ctrl.nx_ds, pv_rd_q, nx_rd_q, v_q, head_q, tail_q, clr_q, clr_last);
		pv_wd  = pick_data(ctrl.pv_ds, pv_rd_q, nx_rd_q, v_q, head_q, tail_q, clr_q, clr_last);
		nx_we  = wcond_ok(ctrl.nx_wc, p_nz, n_nz);
		pv_we  = wcond_ok(ctrl.pv_wc, p_nz, n_nz);
		nx_idx = (ctrl.nx_as == A_CLR) ? clr_q : addr_t'(nx_wa - val_t'(1));
		pv_idx = (ctrl.pv_as == A_CLR) ? clr_q : addr_t'(pv_wa - val_t'(1));
	end

	// link tables
	always_ff @(posedge clk) begin
		if (nx_we) nx_mem[nx_idx] <= nx_wd;
		if (pv_we) pv_mem[pv_idx] <= pv_wd;
		if (accept) begin
			nx_rd_q <= nx_mem[rd_idx];
			pv_rd_q <= pv_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= in_val;
			job_q <= job_in;
		end
		if (emit) begin
			o_next_q <= (job_q == J_READ) ? ((v_q == '0) ? head_q : nx_rd_q) : val_t'(0);
			o_head_q <= head_q;
			o_tail_q <= tail_q;
			o_bad_q  <= (job_q == J_BAD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= val_t'(1);
			tail_q     <= val_t'(ELEMENTS);
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (ctrl.hsel)
				H_N_IF_P0: if (!p_nz) head_q <= nx_rd_q;
				H_V:       head_q <= v_q;
				default:   ;
			endcase
			unique case (ctrl.tsel)
				T_P_IF_N0: if (!n_nz) tail_q <= pv_rd_q;
				T_V:       tail_q <= v_q;
				default:   ;
			endcase
			if (ctrl.op == OP_CLEAR && !clr_last) clr_q <= clr_q + addr_t'(1);
			if (emit)          m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - 3*VAL_W)'(0), o_tail_q, o_head_q, o_next_q};
	assign m_tuser  = o_bad_q;

endmodule

[hdl/mtel_seq.sv]
// ---------------------------------------------------------------------------
// mtel_seq
// Microcode sequencer: step counter, control store and jump logic.
// ---------------------------------------------------------------------------
module mtel_seq
	import mtel_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ctrl_t       ctrl
);

	step_t step_q;
	step_t step_d;

	always_comb begin
		ctrl = '{W_NONE, A_V, D_ZERO, W_NONE, A_V, D_ZERO, H_KEEP, T_KEEP, OP_GOTO, ST_IDLE};
		case (step_q)
			ST_IDLE: ctrl.op = OP_DISPATCH;
			ST_L1, ST_R1: begin
				ctrl = '{W_P_NZ, A_P, D_N, W_N_NZ, A_N, D_P, H_N_IF_P0, T_P_IF_N0,
					OP_NEXT, ST_IDLE};
			end
			ST_L2: ctrl = '{W_ALWAYS, A_V, D_HEAD, W_ALWAYS, A_HEAD, D_V, H_KEEP, T_KEEP,
				OP_NEXT, ST_IDLE};
			ST_L3: ctrl = '{W_NONE, A_V, D_ZERO, W_ALWAYS, A_V, D_ZERO, H_V, T_KEEP,
				OP_GOTO, ST_EMIT};
			ST_R2: ctrl = '{W_ALWAYS, A_TAIL, D_V, W_ALWAYS, A_V, D_TAIL, H_KEEP, T_KEEP,
				OP_NEXT, ST_IDLE};
			ST_R3: ctrl = '{W_ALWAYS, A_V, D_ZERO, W_NONE, A_V, D_ZERO, H_KEEP, T_V,
				OP_GOTO, ST_EMIT};
			ST_EMIT: ctrl.op = OP_WAIT_OUT;
			ST_CLR: ctrl = '{W_ALWAYS, A_CLR, D_CLR_NEXT, W_ALWAYS, A_CLR, D_CLR_PREV,
				H_KEEP, T_KEEP, OP_CLEAR, ST_IDLE};
			default: ;
		endcase
	end

	always_comb begin
		step_d = step_q;
		unique case (ctrl.op)
			OP_NEXT: step_d = step_q + 4'd1;
			OP_GOTO: step_d = ctrl.target;
			OP_DISPATCH: begin
				if (status.accept) begin
					case (status.job)
						J_LEFT:  step_d = ST_L1;
						J_RIGHT: step_d = ST_R1;
						default: step_d = ST_EMIT;
					endcase
				end
			end
			OP_WAIT_OUT: if (status.out_free) step_d = ctrl.target;
			OP_CLEAR:    if (status.clr_last) step_d = ctrl.target;
			default:     step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLR;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[hdl/mtel_chk.sv]
// ---------------------------------------------------------------------------
// mtel_chk
// Port-level checks for the move-to-end order list, bound to the top level.
// ---------------------------------------------------------------------------
module mtel_chk
	import mtel_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[VAL_W-1:0] == '0)
		else $error("flagged request returned a successor");

	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2*VAL_W-1:VAL_W] != '0 && m_tdata[3*VAL_W-1:2*VAL_W] != '0
			&& (ELEMENTS == 1 || m_tdata[2*VAL_W-1:VAL_W] != m_tdata[3*VAL_W-1:2*VAL_W]))
		else $error("head or tail broken");

endmodule

bind move_to_end_order_list mtel_chk u_chk (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stream-level test of the move-to-end order list. Requests are sent with
// random gaps and results taken with random stalls. Each accepted word is
// run through a local model of the linked order, and every result word is
// compared field by field with the oldest prediction. Covered: reads right
// after reset, corner requests, weighted random moves, reads and random raw
// requests, and a final walk over the front of the order.
// ---------------------------------------------------------------------------
module testbench;
	import mtel_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct {
		val_t next_v;
		val_t head_v;
		val_t tail_v;
		logic bad;
	} list_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	val_t link_next [0:ELEMENTS];
	val_t link_prev [0:ELEMENTS];
	val_t list_head;
	val_t list_tail;

	list_result_t results_due [$];
	int unsigned  fail_count = 0;
	bit           calm = 1'b0;
	int unsigned  stall_left = 0;

	move_to_end_order_list uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic void order_reset();
		link_next[0] = '0;
		link_prev[0] = '0;
		for (int i = 1; i <= ELEMENTS; i++) begin
			link_next[i] = (i == ELEMENTS) ? val_t'(0) : val_t'(i + 1);
			link_prev[i] = val_t'(i - 1);
		end
		list_head = val_t'(1);
		list_tail = val_t'(ELEMENTS);
	endfunction

	function automatic void order_unlink(val_t v);
		val_t p;
		val_t n;
		p = link_prev[v];
		n = link_next[v];
		if (p != 0)
			link_next[p] = n;
		else
			list_head = n;
		if (n != 0)
			link_prev[n] = p;
		else
			list_tail = p;
	endfunction

	function automatic list_result_t order_step(logic [1:0] req, val_t v);
		list_result_t r;
		r.next_v = '0;
		r.bad = 1'b0;
		case (req)
			REQ_LEFT, REQ_RIGHT: begin
				if (v == 0 || v > ELEMENTS) begin
					r.bad = 1'b1;
				end else if (req == REQ_LEFT && v != list_head) begin
					order_unlink(v);
					link_prev[list_head] = v;
					link_next[v] = list_head;
					link_prev[v] = '0;
					list_head = v;
				end else if (req == REQ_RIGHT && v != list_tail) begin
					order_unlink(v);
					link_next[list_tail] = v;
					link_prev[v] = list_tail;
					link_next[v] = '0;
					list_tail = v;
				end
			end
			REQ_READ: begin
				if (v > ELEMENTS)
					r.bad = 1'b1;
				else if (v == 0)
					r.next_v = list_head;
				else
					r.next_v = link_next[v];
			end
			default: begin
				r.bad = 1'b1;
			end
		endcase
		r.head_v = list_head;
		r.tail_v = list_tail;
		return r;
	endfunction

	task automatic send_req(input logic [1:0] req, input val_t v);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-VAL_W){1'b0}}, v};
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		results_due.push_back(order_step(req, v));
		gap = idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void check_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
			fail_count++;
		end
	endfunction

	// result side: random stalls, check each word taken
	initial begin
		list_result_t e;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected word, expected none actual %h/%b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					e = results_due.pop_front();
					check_field("next_value", e.next_v, m_tdata[10:0]);
					check_field("head_value", e.head_v, m_tdata[21:11]);
					check_field("tail_value", e.tail_v, m_tdata[32:22]);
					check_field("bad_request", e.bad, m_tuser);
					check_field("tdata padding", 0, m_tdata[OUT_TDATA_W-1:33]);
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= arst_n;
				stall_left = idle_len();
			end
		end
	end

	function automatic val_t pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: return list_head;
			2: return list_tail;
			3: return link_next[list_head];
			4: return link_prev[list_tail];
			5, 6, 7: return val_t'($urandom_range(1, 12));
			default: return val_t'($urandom_range(1, ELEMENTS));
		endcase
	endfunction

	task automatic test_reset_order();
		send_req(REQ_READ, '0);
		for (int i = 1; i <= 4; i++)
			send_req(REQ_READ, val_t'(i));
	endtask

	task automatic test_corner_requests();
		send_req(REQ_READ, val_t'(ELEMENTS));
		send_req(REQ_READ, val_t'(ELEMENTS + 1));
		send_req(REQ_READ, '1);
		send_req(REQ_LEFT, val_t'(1));
		send_req(REQ_RIGHT, val_t'(ELEMENTS));
		send_req(REQ_LEFT, val_t'(ELEMENTS));
		send_req(REQ_RIGHT, val_t'(1));
		send_req(REQ_READ, '0);
		send_req(REQ_READ, val_t'(ELEMENTS - 1));
		send_req(REQ_LEFT, '0);
		send_req(REQ_RIGHT, '0);
		send_req(REQ_LEFT, val_t'(ELEMENTS + 1));
		send_req(REQ_RIGHT, '1);
		send_req(REQ_UNKNOWN, '0);
		send_req(REQ_UNKNOWN, val_t'(5));
		send_req(REQ_UNKNOWN, '1);
		send_req(REQ_LEFT, val_t'(512));
		send_req(REQ_RIGHT, val_t'(513));
		send_req(REQ_LEFT, val_t'(513));
		send_req(REQ_RIGHT, val_t'(ELEMENTS - 1));
		send_req(REQ_READ, val_t'(512));
		send_req(REQ_READ, val_t'(1));
	endtask

	task automatic test_random_traffic();
		int unsigned kind;
		int unsigned steps;
		val_t cur;
		for (int i = 0; i < 270; i++) begin
			calm = ((i % 100) >= 70);
			kind = $urandom_range(0, 99);
			if (kind < 38) begin
				send_req(REQ_LEFT, pick_value());
			end else if (kind < 76) begin
				send_req(REQ_RIGHT, pick_value());
			end else if (kind < 88) begin
				// short walk from the head or from some value
				steps = $urandom_range(2, 6);
				cur = ($urandom_range(0, 1) == 0) ? val_t'(0) : pick_value();
				send_req(REQ_READ, cur);
				cur = (cur == 0) ? list_head : link_next[cur];
				while (steps != 0 && cur != 0) begin
					send_req(REQ_READ, cur);
					cur = link_next[cur];
					steps--;
				end
			end else begin
				send_req(2'($urandom_range(0, 3)), val_t'($urandom_range(0, 2047)));
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_order_walk();
		val_t cur;
		int unsigned steps;
		send_req(REQ_READ, '0);
		cur = list_head;
		steps = 64;
		while (steps != 0 && cur != 0) begin
			send_req(REQ_READ, cur);
			cur = link_next[cur];
			steps--;
		end
	endtask

	initial begin
		order_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_order();
		test_corner_requests();
		test_random_traffic();
		test_order_walk();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("move_to_end_order_list: match");
		else
			$display("move_to_end_order_list: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("%0t: timeout", $time);
		$display("move_to_end_order_list: mismatch");
		$finish;
	end

endmodule

[move_to_end_order_list.f]
hdl/mtel_pkg.sv
hdl/mtel_seq.sv
hdl/move_to_end_order_list.sv
hdl/mtel_chk.sv
verif/testbench.sv
